// File: rtl/fragment_random_access_parser_unit_defines.svh
// Assertion macros used by the fragment random access parser RTL.
`ifndef FRAGMENT_RANDOM_ACCESS_PARSER_UNIT_DEFINES_SVH
`define FRAGMENT_RANDOM_ACCESS_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FRAP_ASSERT_IMPL(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("frap assertion failed");

// Next-cycle implication, disabled during reset.
`define FRAP_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("frap assertion failed");

`endif

// File: rtl/frap_pkg.sv
// Types and constants of the fragment random access parser.
`default_nettype none

package frap_pkg;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PAYLOAD_SIZE = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BOX_VERSION  = 1'd1;

   localparam logic [1:0] STATUS_ENTRY   = 2'd0;
   localparam logic [1:0] STATUS_DONE    = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   localparam logic [31:0] HEADER_BYTES = 32'd12;
   localparam logic [3:0]  TRACK_END    = 4'd3;
   localparam logic [3:0]  FLAGS_END    = 4'd7;
   localparam logic [3:0]  COUNT_END    = 4'd11;
   localparam logic [4:0]  V1_FIXED     = 5'd16;
   localparam logic [4:0]  V0_FIXED     = 5'd8;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       box_start;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] track_number;
      logic [63:0] entry_time;
      logic [63:0] fragment_offset;
      logic [31:0] fragment_number;
      logic [31:0] run_number;
      logic [31:0] sample_index;
      logic [31:0] entry_position;
      logic        last_entry;
   } rsp_type;

   typedef struct packed {
      logic [31:0] payload_size;
      logic        box_version;
   } cfg_type;

   typedef struct packed {
      logic    valid;
      req_type item;
   } q_item_type;

endpackage

`default_nettype wire

// File: rtl/frap_queue.sv
// Front queue: takes input bytes and holds them for the parser.
`default_nettype none

module frap_queue
   import frap_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  req_type     req_payload,
   output q_item_type  head,
   input  wire         pop
);

   req_type     mem_ff [2];
   logic        wr_ptr_ff;
   logic        wr_ptr_in;
   logic        rd_ptr_ff;
   logic        rd_ptr_in;
   logic [1:0]  count_ff;
   logic [1:0]  count_in;
   logic        push;
   logic        take;

   assign req_stall  = (count_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign take       = pop && (count_ff != 2'd0);
   assign head.valid = (count_ff != 2'd0);
   assign head.item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !take) begin
         count_in = count_ff + 2'd1;
      end else if (take && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= req_payload;
      end
   end

endmodule

`default_nettype wire

// File: rtl/frap_parser.sv
// Back end: header and entry parsing with the result register.
`default_nettype none

`include "fragment_random_access_parser_unit_defines.svh"

module frap_parser
   import frap_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  cfg_type     cfg,
   input  q_item_type  head,
   output logic        pop,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output rsp_type     rsp_payload
);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_TIME,
      PH_OFFSET,
      PH_FRAG,
      PH_RUN,
      PH_SAMPLE,
      PH_IDLE
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  bc_ff, bc_in;
   logic [63:0] shift_ff, shift_in;
   logic [31:0] track_ff, track_in;
   logic [2:0]  fw_ff, fw_in;
   logic [2:0]  rw_ff, rw_in;
   logic [2:0]  sw_ff, sw_in;
   logic [31:0] total_ff, total_in;
   logic [31:0] done_ff, done_in;
   logic [63:0] time_ff, time_in;
   logic [63:0] offset_ff, offset_in;
   logic [31:0] frag_ff, frag_in;
   logic [31:0] run_ff, run_in;
   logic        out_valid_ff;
   rsp_type     out_ff;

   logic        fire;
   logic        produce;
   rsp_type     res;
   logic [63:0] val;
   logic [3:0]  at;
   logic [3:0]  bc_inc;
   logic [3:0]  need;
   logic [4:0]  div;
   logic [31:0] rem;
   logic [36:0] prod;

   assign fire        = head.valid && (!out_valid_ff || !rsp_stall);
   assign pop         = fire;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   always_comb begin
      phase_in  = phase_ff;
      bc_in     = bc_ff;
      shift_in  = shift_ff;
      track_in  = track_ff;
      fw_in     = fw_ff;
      rw_in     = rw_ff;
      sw_in     = sw_ff;
      total_in  = total_ff;
      done_in   = done_ff;
      time_in   = time_ff;
      offset_in = offset_ff;
      frag_in   = frag_ff;
      run_in    = run_ff;
      produce   = 1'b0;
      res       = '0;

      if (fire && head.item.box_start) begin
         phase_in = PH_HEADER;
         bc_in    = 4'd0;
         shift_in = 64'd0;
         fw_in    = 3'd1;
         rw_in    = 3'd1;
         sw_in    = 3'd1;
         total_in = 32'd0;
         done_in  = 32'd0;
      end

      at     = bc_in;
      bc_inc = bc_in + 4'd1;
      val    = {shift_in[55:0], head.item.data_byte};
      div    = (cfg.box_version ? V1_FIXED : V0_FIXED) + {2'b00, fw_in} + {2'b00, rw_in}
               + {2'b00, sw_in};
      rem    = (cfg.payload_size >= HEADER_BYTES) ? (cfg.payload_size - HEADER_BYTES) : 32'd0;
      prod   = {5'd0, val[31:0]} * {32'd0, div};
      need   = 4'd0;

      if (fire) begin
         unique case (phase_in)
            PH_IDLE: begin
            end
            PH_HEADER: begin
               if (at == 4'd0 && cfg.payload_size < HEADER_BYTES) begin
                  produce       = 1'b1;
                  res.status    = STATUS_INVALID;
                  res.last_entry = 1'b1;
                  phase_in      = PH_IDLE;
               end else begin
                  shift_in = val;
                  bc_in    = bc_inc;
                  if (at == TRACK_END) begin
                     track_in = val[31:0];
                     shift_in = 64'd0;
                  end else if (at == FLAGS_END) begin
                     shift_in = 64'd0;
                     if (val[31:6] != 26'd0) begin
                        produce        = 1'b1;
                        res.status     = STATUS_INVALID;
                        res.last_entry = 1'b1;
                        phase_in       = PH_IDLE;
                     end else begin
                        fw_in = {1'b0, val[5:4]} + 3'd1;
                        rw_in = {1'b0, val[3:2]} + 3'd1;
                        sw_in = {1'b0, val[1:0]} + 3'd1;
                     end
                  end else if (at >= COUNT_END) begin
                     total_in = val[31:0];
                     shift_in = 64'd0;
                     bc_in    = 4'd0;
                     if (prod > {5'd0, rem}) begin
                        produce        = 1'b1;
                        res.status     = STATUS_INVALID;
                        res.last_entry = 1'b1;
                        phase_in       = PH_IDLE;
                     end else if (val[31:0] == 32'd0) begin
                        produce        = 1'b1;
                        res.status     = STATUS_DONE;
                        res.last_entry = 1'b1;
                        phase_in       = PH_IDLE;
                     end else begin
                        done_in  = 32'd0;
                        phase_in = PH_TIME;
                     end
                  end
               end
            end
            default: begin
               case (phase_in) inside
                  PH_TIME, PH_OFFSET: need = cfg.box_version ? 4'd8 : 4'd4;
                  PH_FRAG:            need = {1'b0, fw_in};
                  PH_RUN:             need = {1'b0, rw_in};
                  default:            need = {1'b0, sw_in};
               endcase
               bc_in    = bc_inc;
               shift_in = val;
               if (bc_inc >= need) begin
                  bc_in    = 4'd0;
                  shift_in = 64'd0;
                  case (phase_in)
                     PH_TIME: begin
                        time_in  = cfg.box_version ? val : {32'd0, val[31:0]};
                        phase_in = PH_OFFSET;
                     end
                     PH_OFFSET: begin
                        offset_in = cfg.box_version ? val : {32'd0, val[31:0]};
                        phase_in  = PH_FRAG;
                     end
                     PH_FRAG: begin
                        frag_in  = val[31:0];
                        phase_in = PH_RUN;
                     end
                     PH_RUN: begin
                        run_in   = val[31:0];
                        phase_in = PH_SAMPLE;
                     end
                     default: begin
                        produce             = 1'b1;
                        res.status          = STATUS_ENTRY;
                        res.track_number    = track_in;
                        res.entry_time      = time_in;
                        res.fragment_offset = offset_in;
                        res.fragment_number = frag_in;
                        res.run_number      = run_in;
                        res.sample_index    = val[31:0];
                        res.entry_position  = done_in;
                        res.last_entry      = ((done_in + 32'd1) == total_in);
                        done_in             = done_in + 32'd1;
                        phase_in            = (done_in == total_in) ? PH_IDLE : PH_TIME;
                     end
                  endcase
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         bc_ff        <= 4'd0;
         shift_ff     <= 64'd0;
         track_ff     <= 32'd0;
         fw_ff        <= 3'd1;
         rw_ff        <= 3'd1;
         sw_ff        <= 3'd1;
         total_ff     <= 32'd0;
         done_ff      <= 32'd0;
         time_ff      <= 64'd0;
         offset_ff    <= 64'd0;
         frag_ff      <= 32'd0;
         run_ff       <= 32'd0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         bc_ff     <= bc_in;
         shift_ff  <= shift_in;
         track_ff  <= track_in;
         fw_ff     <= fw_in;
         rw_ff     <= rw_in;
         sw_ff     <= sw_in;
         total_ff  <= total_in;
         done_ff   <= done_in;
         time_ff   <= time_in;
         offset_ff <= offset_in;
         frag_ff   <= frag_in;
         run_ff    <= run_in;
         if (produce) begin
            out_valid_ff <= 1'b1;
            out_ff       <= res;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   `FRAP_ASSERT_IMPL(a_flag_is_last, out_valid_ff && out_ff.status != STATUS_ENTRY, out_ff.last_entry)
   `FRAP_ASSERT_NEXT(a_last_goes_idle, produce && res.last_entry, phase_ff == PH_IDLE)
   `FRAP_ASSERT_IMPL(a_header_count, phase_ff == PH_HEADER, bc_ff <= COUNT_END)
   `FRAP_ASSERT_IMPL(a_position_range, out_valid_ff && out_ff.status == STATUS_ENTRY, out_ff.entry_position < total_ff)

endmodule

`default_nettype wire

// File: rtl/fragment_random_access_parser_unit.sv
// Top level of the fragment random access parser: registers, queue and parser.
//
//   channel  direction  handshake         payload
//   req      in         req_valid/stall   req_type: data_byte, box_start
//   rsp      out        rsp_valid/stall   rsp_type: status .. last_entry
//   csr      in         csr_valid/ready   csr_index, csr_data
//
// One byte per cycle while no result is stalled; a byte is registered in the queue,
// parsed at the head, and a completed result is offered on rsp from the following edge.
// The parse state register and the one-entry result register set the rate.
// Synchronous reset clears control state; no clearing pass is needed.
// A stalled result blocks parsing; the two-entry queue keeps taking bytes until full.
`default_nettype none

module fragment_random_access_parser_unit
   import frap_pkg::*;
(
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  req_type                    req_payload,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output rsp_type                    rsp_payload,
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire [CSR_DATA_WIDTH-1:0]   csr_data
);

   cfg_type     cfg_ff;
   q_item_type  head;
   logic        pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PAYLOAD_SIZE: cfg_ff.payload_size <= csr_data;
            CSR_BOX_VERSION:  cfg_ff.box_version  <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   frap_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .head        (head),
      .pop         (pop)
   );

   frap_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// File: bench/testbench.sv
// Self-checking bench for the fragment random access parser: streamed boxes, predicted entries.
`timescale 1ns / 100ps

module testbench;
   import frap_pkg::*;

   typedef enum logic [2:0] {
      PARSE_HEADER, PARSE_TIME, PARSE_OFFSET, PARSE_FRAGMENT, PARSE_RUN, PARSE_SAMPLE, PARSE_IDLE
   } parse_state_type;

   localparam int WATCHDOG_LIMIT = 3000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_data = '0;

   fragment_random_access_parser_unit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   req_type bytes_to_send[$];
   rsp_type records_due[$];

   // register copies
   logic [31:0] cfg_payload_size;
   logic cfg_box_version;

   // parser copy
   parse_state_type parse_state;
   logic [3:0] byte_index;
   logic [63:0] shift_reg;
   logic [31:0] track_word;
   logic [2:0] frag_bytes, run_bytes, sample_bytes;
   logic [31:0] entry_count, entries_seen;
   logic [63:0] time_val, offset_val;
   logic [31:0] fragment_val, run_val;

   int failures = 0;
   int burst_left = 0;
   int gap_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int stall_mode = 0;
   int mode_left = 0;
   int idle_cycles = 0;

   function automatic void restart_box();
      parse_state = PARSE_HEADER;
      byte_index = '0;
      shift_reg = '0;
      track_word = '0;
      frag_bytes = 3'd1;
      run_bytes = 3'd1;
      sample_bytes = 3'd1;
      entry_count = '0;
      entries_seen = '0;
      time_val = '0;
      offset_val = '0;
      fragment_val = '0;
      run_val = '0;
   endfunction

   function automatic void close_box(output rsp_type rec, input logic [1:0] code);
      rec = '0;
      rec.status = code;
      rec.last_entry = 1'b1;
      parse_state = PARSE_IDLE;
   endfunction

   function automatic bit parse_byte(input req_type item, output rsp_type rec);
      logic [63:0] val, divisor, room;
      logic [3:0] at, need;
      logic [31:0] flags;
      rec = '0;
      if (item.box_start)
         restart_box();
      if (parse_state == PARSE_IDLE)
         return 1'b0;
      if (parse_state == PARSE_HEADER && byte_index == 4'd0 && cfg_payload_size < HEADER_BYTES) begin
         close_box(rec, STATUS_INVALID);
         return 1'b1;
      end
      shift_reg = {shift_reg[55:0], item.data_byte};
      val = shift_reg;
      if (parse_state == PARSE_HEADER) begin
         at = byte_index;
         byte_index = byte_index + 4'd1;
         if (at == TRACK_END) begin
            track_word = val[31:0];
            shift_reg = '0;
         end else if (at == FLAGS_END) begin
            flags = val[31:0];
            shift_reg = '0;
            if (flags[31:6] != 26'd0) begin
               close_box(rec, STATUS_INVALID);
               return 1'b1;
            end
            frag_bytes = {1'b0, flags[5:4]} + 3'd1;
            run_bytes = {1'b0, flags[3:2]} + 3'd1;
            sample_bytes = {1'b0, flags[1:0]} + 3'd1;
         end else if (at >= COUNT_END) begin
            divisor = 64'(cfg_box_version ? V1_FIXED : V0_FIXED) + 64'(frag_bytes)
                      + 64'(run_bytes) + 64'(sample_bytes);
            room = (cfg_payload_size >= HEADER_BYTES) ? 64'(cfg_payload_size - HEADER_BYTES) : 64'd0;
            entry_count = val[31:0];
            shift_reg = '0;
            byte_index = '0;
            if (64'(entry_count) * divisor > room) begin
               close_box(rec, STATUS_INVALID);
               return 1'b1;
            end
            if (entry_count == 32'd0) begin
               close_box(rec, STATUS_DONE);
               return 1'b1;
            end
            entries_seen = '0;
            parse_state = PARSE_TIME;
         end
         return 1'b0;
      end
      case (parse_state) inside
         PARSE_TIME, PARSE_OFFSET: need = cfg_box_version ? 4'd8 : 4'd4;
         PARSE_FRAGMENT: need = {1'b0, frag_bytes};
         PARSE_RUN: need = {1'b0, run_bytes};
         default: need = {1'b0, sample_bytes};
      endcase
      byte_index = byte_index + 4'd1;
      if (byte_index < need)
         return 1'b0;
      byte_index = '0;
      shift_reg = '0;
      case (parse_state)
         PARSE_TIME: begin
            time_val = cfg_box_version ? val : {32'h0, val[31:0]};
            parse_state = PARSE_OFFSET;
            return 1'b0;
         end
         PARSE_OFFSET: begin
            offset_val = cfg_box_version ? val : {32'h0, val[31:0]};
            parse_state = PARSE_FRAGMENT;
            return 1'b0;
         end
         PARSE_FRAGMENT: begin
            fragment_val = val[31:0];
            parse_state = PARSE_RUN;
            return 1'b0;
         end
         PARSE_RUN: begin
            run_val = val[31:0];
            parse_state = PARSE_SAMPLE;
            return 1'b0;
         end
         default: ;
      endcase
      rec.status = STATUS_ENTRY;
      rec.track_number = track_word;
      rec.entry_time = time_val;
      rec.fragment_offset = offset_val;
      rec.fragment_number = fragment_val;
      rec.run_number = run_val;
      rec.sample_index = val[31:0];
      rec.entry_position = entries_seen;
      rec.last_entry = (entries_seen + 32'd1 == entry_count);
      entries_seen = entries_seen + 32'd1;
      if (entries_seen == entry_count)
         parse_state = PARSE_IDLE;
      else
         parse_state = PARSE_TIME;
      return 1'b1;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endfunction

   function automatic logic [63:0] random_value(input int nbytes);
      logic [63:0] mask, pick;
      mask = (nbytes >= 8) ? '1 : ((64'd1 << (8 * nbytes)) - 64'd1);
      case ($urandom_range(0, 5))
         0: pick = '0;
         1: pick = '1;
         default: pick = {$urandom, $urandom};
      endcase
      return pick & mask;
   endfunction

   function automatic void queue_field(input logic [63:0] value, input int nbytes,
                                       input logic start);
      for (int i = nbytes - 1; i >= 0; i--)
         bytes_to_send.push_back(req_type'{data_byte: value[8*i +: 8],
                                           box_start: start && (i == nbytes - 1)});
   endfunction

   function automatic logic [31:0] fit_count(input logic [31:0] flags);
      logic [63:0] divisor, room;
      divisor = (cfg_box_version ? 64'd16 : 64'd8) + 64'(flags[5:4]) + 64'(flags[3:2])
                + 64'(flags[1:0]) + 64'd3;
      room = (cfg_payload_size >= HEADER_BYTES) ? 64'(cfg_payload_size - HEADER_BYTES) : 64'd0;
      return 32'(room / divisor);
   endfunction

   // header plus the given number of entries, field widths taken from the flags word and the box version
   function automatic void queue_box(input logic [31:0] track, input logic [31:0] flags,
                                     input logic [31:0] count, input int entries);
      int wide;
      wide = cfg_box_version ? 8 : 4;
      queue_field(track, 4, 1'b1);
      queue_field(flags, 4, 1'b0);
      queue_field(count, 4, 1'b0);
      repeat (entries) begin
         queue_field(random_value(wide), wide, 1'b0);
         queue_field(random_value(wide), wide, 1'b0);
         queue_field(random_value(int'(flags[5:4]) + 1), int'(flags[5:4]) + 1, 1'b0);
         queue_field(random_value(int'(flags[3:2]) + 1), int'(flags[3:2]) + 1, 1'b0);
         queue_field(random_value(int'(flags[1:0]) + 1), int'(flags[1:0]) + 1, 1'b0);
      end
   endfunction

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_PAYLOAD_SIZE)
         cfg_payload_size = value;
      else
         cfg_box_version = value[0];
   endtask

   task automatic configure(input logic [31:0] size, input logic version);
      write_csr(CSR_PAYLOAD_SIZE, size);
      write_csr(CSR_BOX_VERSION, {31'd0, version});
   endtask

   task automatic drain();
      do @(posedge clock); while (bytes_to_send.size() != 0 || req_valid);
      while (records_due.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // byte driver: bursts with random gaps; predicts on every transfer
   always @(posedge clock) begin
      rsp_type rec;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (parse_byte(req_payload, rec))
               records_due.push_back(rec);
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (bytes_to_send.size() != 0) begin
               req_valid <= 1'b1;
               req_payload <= bytes_to_send.pop_front();
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stall pattern
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (records_due.size() == 0) begin
               $error("result with no entry pending: status %0d", rsp_payload.status);
               failures++;
            end else begin
               want = records_due.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_payload.status));
               check_field("track_number", 64'(want.track_number),
                           64'(rsp_payload.track_number));
               check_field("entry_time", want.entry_time, rsp_payload.entry_time);
               check_field("fragment_offset", want.fragment_offset, rsp_payload.fragment_offset);
               check_field("fragment_number", 64'(want.fragment_number),
                           64'(rsp_payload.fragment_number));
               check_field("run_number", 64'(want.run_number), 64'(rsp_payload.run_number));
               check_field("sample_index", 64'(want.sample_index),
                           64'(rsp_payload.sample_index));
               check_field("entry_position", 64'(want.entry_position),
                           64'(rsp_payload.entry_position));
               check_field("last_entry", 64'(want.last_entry), 64'(rsp_payload.last_entry));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && rsp_valid && bytes_to_send.size() > 40) begin
            // long hold so the input queue backs up
            hold_done = 1'b1;
            hold_left = 120;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left <= 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left = $urandom_range(32, 256);
            end
            mode_left--;
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 2) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= mode_left[2];
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      logic [31:0] flags, count, fit;
      int entries;
      cfg_payload_size = '0;
      cfg_box_version = 1'b0;
      restart_box();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // short payload with registers at reset, then an ignored byte
      queue_field(64'hA5, 1, 1'b1);
      queue_field(64'h5A, 1, 1'b0);
      drain();
      configure(32'd11, 1'b0);
      queue_field(64'hFFFF_FFFF, 4, 1'b1);
      drain();

      // header-only payload: empty table, count too big, reserved bits
      configure(HEADER_BYTES, 1'b0);
      queue_box(32'hFFFF_FFFF, 32'h0, 32'd0, 0);
      queue_box(32'h0, 32'h0, 32'd1, 0);
      queue_box(32'h1, 32'h0000_0040, 32'd0, 0);
      queue_box(32'h2, 32'h8000_0000, 32'd0, 0);
      drain();

      // exact fit and one over
      configure(32'd34, 1'b0);
      queue_box(32'h1234_5678, 32'h0, 32'd2, 2);
      queue_box(32'h1234_5678, 32'h0, 32'd3, 0);
      drain();

      configure(32'hFFFF_FFFF, 1'b1);
      queue_box(32'hFFFF_FFFF, 32'h3F, 32'd2, 2);
      queue_box(32'h7, 32'h3F, 32'hFFFF_FFFF, 0);
      queue_box(32'h8, 32'h3F, fit_count(32'h3F), 1);
      queue_box(32'h9, 32'h24, 32'd1, 1);
      drain();

      // version flips in mid-entry
      configure(32'd200, 1'b0);
      queue_box(32'h0A0A, 32'h15, 32'd2, 0);
      queue_field(random_value(4), 4, 1'b0);
      drain();
      configure(32'd200, 1'b1);
      repeat (40) queue_field(64'($urandom_range(0, 255)), 1, 1'b0);
      drain();

      // size shrinks in mid-header
      configure(32'd100, 1'b0);
      queue_field(64'($urandom), 4, 1'b1);
      queue_field(64'h0, 2, 1'b0);
      drain();
      configure(32'd11, 1'b0);
      queue_field(64'h0, 2, 1'b0);
      queue_field(64'd1, 4, 1'b0);
      drain();

      repeat (8) begin
         case ($urandom_range(0, 9))
            0: configure($urandom_range(0, 11), 1'($urandom_range(0, 1)));
            1: configure(32'hFFFF_FFFF, 1'($urandom_range(0, 1)));
            2: configure($urandom, 1'($urandom_range(0, 1)));
            default: configure($urandom_range(12, 400), 1'($urandom_range(0, 1)));
         endcase
         while (bytes_to_send.size() < 50) begin
            case ($urandom_range(0, 9))
               7: begin
                  flags = $urandom | (32'd1 << $urandom_range(6, 31));
                  queue_box($urandom, flags, $urandom, 0);
               end
               8: begin
                  flags = $urandom_range(0, 63);
                  fit = fit_count(flags);
                  count = ($urandom_range(0, 3) == 0) ? $urandom : fit + $urandom_range(1, 4);
                  if (count <= fit)
                     count = fit + 32'd1;
                  queue_box($urandom, flags, count, 0);
               end
               9: begin
                  queue_field(64'($urandom_range(0, 255)), 1, 1'($urandom_range(0, 1)));
                  repeat ($urandom_range(0, 19))
                     queue_field(64'($urandom_range(0, 255)), 1, ($urandom_range(0, 7) == 0));
               end
               default: begin
                  flags = $urandom_range(0, 63);
                  fit = fit_count(flags);
                  count = (fit == 0) ? 32'd0 : $urandom_range(1, (fit > 4) ? 4 : fit);
                  entries = int'(count);
                  if (count != 0 && $urandom_range(0, 7) == 0)
                     entries = $urandom_range(0, entries - 1);
                  queue_box(32'(random_value(4)), flags, count, entries);
               end
            endcase
         end
         drain();
      end

      repeat (8) @(posedge clock);
      if (failures == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/frap_pkg.sv
rtl/frap_queue.sv
rtl/frap_parser.sv
rtl/fragment_random_access_parser_unit.sv
bench/testbench.sv
